// File: rtl/zfs_pkg.sv
// shared types, widths and constants of the zero moment point block
`timescale 1ns / 1ps

package zfs_pkg;

    localparam int unsigned FIELD_W  = 24;
    localparam int unsigned TORQUE_W = 40;
    localparam int unsigned THR_W    = 23;
    localparam int unsigned HGT_W    = 16;
    localparam int unsigned CFG_W    = 23;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned OPND_W = FIELD_W + 1;
    localparam int unsigned NUM_W  = 2 * OPND_W;
    localparam int unsigned MAG_W  = NUM_W - 1;
    localparam int unsigned DEN_W  = FIELD_W + 1;
    localparam int unsigned SC_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_UNLOAD_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_HEIGHT    = 2'd1;

    localparam logic [THR_W-1:0] THR_RESET = 23'd150000;
    localparam logic [HGT_W-1:0] HGT_RESET = 16'd26000;

    localparam logic [SC_W-1:0] SC_NONE  = 2'd0;
    localparam logic [SC_W-1:0] SC_RIGHT = 2'd1;
    localparam logic [SC_W-1:0] SC_LEFT  = 2'd2;
    localparam logic [SC_W-1:0] SC_BOTH  = 2'd3;

    localparam logic FOOT_RIGHT = 1'b0;

    typedef struct packed {
        logic                       foot_select;
        logic signed [FIELD_W-1:0]  force_x;
        logic signed [FIELD_W-1:0]  force_y;
        logic signed [FIELD_W-1:0]  force_z;
        logic signed [TORQUE_W-1:0] torque_x;
        logic signed [TORQUE_W-1:0] torque_y;
        logic signed [FIELD_W-1:0]  foot_pos_x;
        logic signed [FIELD_W-1:0]  foot_pos_y;
    } zfs_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] zmp_x;
        logic signed [FIELD_W-1:0] zmp_y;
        logic [SC_W-1:0]           support_case;
        logic                      saturated;
    } zfs_out_t;

    typedef struct packed {
        logic en;
        logic clr;
        logic neg;
    } mac_op_t;

endpackage

// File: rtl/zfs_mac.sv
// shared multiply-accumulate unit for numerators
`timescale 1ns / 1ps

module zfs_mac
    import zfs_pkg::*;
(
    input  logic                     clk,
    input  mac_op_t                  op,
    input  logic signed [NUM_W-1:0]  base,
    input  logic signed [OPND_W-1:0] a,
    input  logic signed [OPND_W-1:0] b,
    output logic signed [NUM_W-1:0]  acc
);

    logic signed [NUM_W-1:0] prod;
    logic signed [NUM_W-1:0] acc_reg;
    logic signed [NUM_W-1:0] acc_next;

    assign prod = a * b;

    always_comb
    begin
        acc_next = (op.clr ? base : acc_reg) + (op.neg ? -prod : prod);
    end

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// File: rtl/zfs_div.sv
// iterative signed by positive divider with 24-bit saturating quotient
`timescale 1ns / 1ps

module zfs_div
    import zfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]          den,
    output logic                      done,
    output logic signed [FIELD_W-1:0] quo,
    output logic                      sat
);

    localparam int unsigned CNT_W = $clog2(FIELD_W);
    localparam int unsigned DSH_W = DEN_W + FIELD_W - 1;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CHK  = 2'd1;
    localparam logic [1:0] D_ITER = 2'd2;
    localparam logic [1:0] D_DONE = 2'd3;

    localparam logic signed [FIELD_W-1:0] Q_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] Q_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [MAG_W-1:0]         rem_reg;
    logic [DSH_W-1:0]         dsh_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [FIELD_W-1:0]       q_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     neg_reg;
    logic signed [FIELD_W-1:0] quo_reg;
    logic                     sat_reg;

    logic [NUM_W-1:0]         mag_full;
    logic [MAG_W-1:0]         lim;
    logic [MAG_W-1:0]         dsh_ext;
    logic                     ge;
    logic [FIELD_W-1:0]       q_new;
    logic signed [FIELD_W-1:0] q_val;
    logic                     q_sat;

    assign mag_full = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign lim      = {den_reg, {FIELD_W{1'b0}}};
    assign dsh_ext  = {1'b0, dsh_reg};
    assign ge       = rem_reg >= dsh_ext;
    assign q_new    = {q_reg[FIELD_W-2:0], ge};

    // sign and clamp of the final magnitude
    always_comb
    begin
        q_sat = 1'b0;
        q_val = $signed(q_new);
        if (!neg_reg)
        begin
            if (q_new[FIELD_W-1])
            begin
                q_sat = 1'b1;
                q_val = Q_MAX;
            end
        end
        else
        begin
            if (q_new[FIELD_W-1] && (|q_new[FIELD_W-2:0]))
            begin
                q_sat = 1'b1;
                q_val = Q_MIN;
            end
            else
            begin
                q_val = $signed(-q_new);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: if (start) state_next = D_CHK;
            D_CHK:  state_next = (rem_reg >= lim) ? D_DONE : D_ITER;
            D_ITER: if (cnt_reg == '0) state_next = D_DONE;
            D_DONE: state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_reg <= num[NUM_W-1];
                    rem_reg <= mag_full[MAG_W-1:0];
                    den_reg <= den;
                end
            end
            D_CHK:
            begin
                if (rem_reg >= lim)
                begin
                    // quotient magnitude reaches 2^24, clamps either way
                    quo_reg <= neg_reg ? Q_MIN : Q_MAX;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    dsh_reg <= {den_reg, {(FIELD_W-1){1'b0}}};
                    cnt_reg <= CNT_W'(FIELD_W - 1);
                    q_reg   <= '0;
                end
            end
            D_ITER:
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - dsh_ext;
                end
                q_reg   <= q_new;
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    quo_reg <= q_val;
                    sat_reg <= q_sat;
                end
            end
            D_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == D_DONE);
    assign quo  = quo_reg;
    assign sat  = sat_reg;

endmodule

// File: rtl/zmp_from_foot_force_sensors.sv
// top level: sequencer, right foot store and result register of the zmp block
//
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    in_data  (zfs_in_t, one foot sample)
// out      out  out_valid / out_ready  out_data (zfs_out_t, zmp and flags)
// cfg      in   cfg_we                 cfg_index, cfg_data
//
// an unloaded foot skips the arithmetic; a loaded foot runs two numerators
// on the shared multiplier and two 24-step divisions
// a left beat with both feet loaded adds two more divisions for the weighted mean
// a quotient that clamps early skips its 24 division steps
// reset idles the sequencer, clears out_valid and the right foot store to an unloaded origin
// in_ready is low while a beat is worked; a result waiting on out_ready holds
// the next result in the final step, and no beat is taken meanwhile
`timescale 1ns / 1ps

module zmp_from_foot_force_sensors
    import zfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  zfs_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output zfs_out_t             out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M0   = 3'd1;
    localparam logic [2:0] S_M1   = 3'd2;
    localparam logic [2:0] S_DS   = 3'd3;
    localparam logic [2:0] S_DW   = 3'd4;
    localparam logic [2:0] S_PICK = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;

    logic [THR_W-1:0]          thr_reg;
    logic [HGT_W-1:0]          hgt_reg;

    zfs_in_t                   in_reg;
    logic                      ld_reg;
    logic                      mode_reg;
    logic                      axis_reg;
    logic                      sat_reg;
    logic [SC_W-1:0]           sc_reg;
    logic signed [FIELD_W-1:0] cx_reg;
    logic signed [FIELD_W-1:0] cy_reg;
    logic signed [FIELD_W-1:0] zx_reg;
    logic signed [FIELD_W-1:0] zy_reg;

    logic signed [FIELD_W-1:0] rcx_reg;
    logic signed [FIELD_W-1:0] rcy_reg;
    logic signed [FIELD_W-1:0] rfz_reg;
    logic                      rld_reg;
    logic signed [FIELD_W-1:0] rpx_reg;
    logic signed [FIELD_W-1:0] rpy_reg;
    logic                      rsat_reg;

    logic                      out_valid_reg;
    zfs_out_t                  out_data_reg;

    logic                      in_fire;
    logic                      in_loaded;
    logic                      out_load;
    logic [SC_W-1:0]           sc_now;

    mac_op_t                   mac_op;
    logic signed [NUM_W-1:0]   mac_base;
    logic signed [OPND_W-1:0]  mac_a;
    logic signed [OPND_W-1:0]  mac_b;
    logic signed [NUM_W-1:0]   mac_acc;

    logic [DEN_W-1:0]          div_den;
    logic                      div_done;
    logic signed [FIELD_W-1:0] div_quo;
    logic                      div_sat;

    logic signed [FIELD_W:0]   mid_x_sum;
    logic signed [FIELD_W:0]   mid_y_sum;
    logic signed [FIELD_W:0]   mid_x;
    logic signed [FIELD_W:0]   mid_y;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign in_loaded = (in_data.force_z > 0) &&
                       (in_data.force_z >= $signed({1'b0, thr_reg}));
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign sc_now    = {ld_reg, rld_reg};

    // midpoint truncated toward zero
    assign mid_x_sum = {rpx_reg[FIELD_W-1], rpx_reg} +
                       {in_reg.foot_pos_x[FIELD_W-1], in_reg.foot_pos_x};
    assign mid_y_sum = {rpy_reg[FIELD_W-1], rpy_reg} +
                       {in_reg.foot_pos_y[FIELD_W-1], in_reg.foot_pos_y};
    assign mid_x     = (mid_x_sum + {{FIELD_W{1'b0}}, mid_x_sum[FIELD_W]}) >>> 1;
    assign mid_y     = (mid_y_sum + {{FIELD_W{1'b0}}, mid_y_sum[FIELD_W]}) >>> 1;

    // operand selection for the shared multiplier and the divisor of the divider
    always_comb
    begin
        mac_op.en  = (state_reg == S_M0) || (state_reg == S_M1);
        mac_op.clr = (state_reg == S_M0);
        mac_op.neg = 1'b0;
        mac_base   = '0;
        mac_a      = '0;
        mac_b      = '0;
        div_den    = '0;
        unique case ({mode_reg, axis_reg})
            2'b00:
            begin
                div_den = {1'b0, in_reg.force_z};
                if (state_reg == S_M0)
                begin
                    mac_op.neg = 1'b1;
                    mac_base   = -{{(NUM_W-TORQUE_W){in_reg.torque_y[TORQUE_W-1]}},
                                   in_reg.torque_y};
                    mac_a      = {{(OPND_W-HGT_W){1'b0}}, hgt_reg};
                    mac_b      = {in_reg.force_x[FIELD_W-1], in_reg.force_x};
                end
                else
                begin
                    mac_a = {in_reg.foot_pos_x[FIELD_W-1], in_reg.foot_pos_x};
                    mac_b = {in_reg.force_z[FIELD_W-1], in_reg.force_z};
                end
            end
            2'b01:
            begin
                div_den = {1'b0, in_reg.force_z};
                if (state_reg == S_M0)
                begin
                    mac_op.neg = 1'b1;
                    mac_base   = {{(NUM_W-TORQUE_W){in_reg.torque_x[TORQUE_W-1]}},
                                  in_reg.torque_x};
                    mac_a      = {{(OPND_W-HGT_W){1'b0}}, hgt_reg};
                    mac_b      = {in_reg.force_y[FIELD_W-1], in_reg.force_y};
                end
                else
                begin
                    mac_a = {in_reg.foot_pos_y[FIELD_W-1], in_reg.foot_pos_y};
                    mac_b = {in_reg.force_z[FIELD_W-1], in_reg.force_z};
                end
            end
            2'b10:
            begin
                div_den = DEN_W'({1'b0, rfz_reg}) + DEN_W'({1'b0, in_reg.force_z});
                if (state_reg == S_M0)
                begin
                    mac_a = {rcx_reg[FIELD_W-1], rcx_reg};
                    mac_b = {rfz_reg[FIELD_W-1], rfz_reg};
                end
                else
                begin
                    mac_a = {cx_reg[FIELD_W-1], cx_reg};
                    mac_b = {in_reg.force_z[FIELD_W-1], in_reg.force_z};
                end
            end
            2'b11:
            begin
                div_den = DEN_W'({1'b0, rfz_reg}) + DEN_W'({1'b0, in_reg.force_z});
                if (state_reg == S_M0)
                begin
                    mac_a = {rcy_reg[FIELD_W-1], rcy_reg};
                    mac_b = {rfz_reg[FIELD_W-1], rfz_reg};
                end
                else
                begin
                    mac_a = {cy_reg[FIELD_W-1], cy_reg};
                    mac_b = {in_reg.force_z[FIELD_W-1], in_reg.force_z};
                end
            end
            default:
            begin
            end
        endcase
    end

    zfs_mac u_mac (
        .clk  (clk),
        .op   (mac_op),
        .base (mac_base),
        .a    (mac_a),
        .b    (mac_b),
        .acc  (mac_acc)
    );

    zfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DS),
        .num   (mac_acc),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .sat   (div_sat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = in_loaded ? S_M0 : S_PICK;
            S_M0:   state_next = S_M1;
            S_M1:   state_next = S_DS;
            S_DS:   state_next = S_DW;
            S_DW:
            begin
                if (div_done)
                begin
                    if (!axis_reg)
                    begin
                        state_next = S_M0;
                    end
                    else
                    begin
                        state_next = mode_reg ? S_FIN : S_PICK;
                    end
                end
            end
            S_PICK:
            begin
                if (in_reg.foot_select == FOOT_RIGHT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = (sc_now == SC_BOTH) ? S_M0 : S_FIN;
                end
            end
            S_FIN:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= THR_RESET;
            hgt_reg       <= HGT_RESET;
            out_valid_reg <= 1'b0;
            rcx_reg       <= '0;
            rcy_reg       <= '0;
            rfz_reg       <= '0;
            rld_reg       <= 1'b0;
            rpx_reg       <= '0;
            rpy_reg       <= '0;
            rsat_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_UNLOAD_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                    CFG_SENSOR_HEIGHT:    hgt_reg <= cfg_data[HGT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == S_PICK) && (in_reg.foot_select == FOOT_RIGHT))
            begin
                rcx_reg  <= cx_reg;
                rcy_reg  <= cy_reg;
                rfz_reg  <= in_reg.force_z;
                rld_reg  <= ld_reg;
                rpx_reg  <= in_reg.foot_pos_x;
                rpy_reg  <= in_reg.foot_pos_y;
                rsat_reg <= sat_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    in_reg   <= in_data;
                    ld_reg   <= in_loaded;
                    sat_reg  <= 1'b0;
                    cx_reg   <= '0;
                    cy_reg   <= '0;
                    mode_reg <= 1'b0;
                    axis_reg <= 1'b0;
                end
            end
            S_DW:
            begin
                if (div_done)
                begin
                    sat_reg  <= sat_reg | div_sat;
                    axis_reg <= ~axis_reg;
                    unique case ({mode_reg, axis_reg})
                        2'b00: cx_reg <= div_quo;
                        2'b01: cy_reg <= div_quo;
                        2'b10: zx_reg <= div_quo;
                        2'b11: zy_reg <= div_quo;
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PICK:
            begin
                sc_reg  <= sc_now;
                sat_reg <= sat_reg | rsat_reg;
                unique case (sc_now)
                    SC_NONE:
                    begin
                        zx_reg <= mid_x[FIELD_W-1:0];
                        zy_reg <= mid_y[FIELD_W-1:0];
                    end
                    SC_RIGHT:
                    begin
                        zx_reg <= rcx_reg;
                        zy_reg <= rcy_reg;
                    end
                    SC_LEFT:
                    begin
                        zx_reg <= cx_reg;
                        zy_reg <= cy_reg;
                    end
                    SC_BOTH:
                    begin
                        mode_reg <= 1'b1;
                        axis_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    out_data_reg.zmp_x        <= zx_reg;
                    out_data_reg.zmp_y        <= zy_reg;
                    out_data_reg.support_case <= sc_reg;
                    out_data_reg.saturated    <= sat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
